FILE: src/rotated_blit_address_generator_assert.svh
// assertion macros shared by the rotated blit address generator rtl
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ROTATED_BLIT_ADDRESS_GENERATOR_ASSERT_SVH
`define ROTATED_BLIT_ADDRESS_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property checked on every rising clock edge outside reset
`define RBAG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// antecedent on one edge implies consequent on the next edge
`define RBAG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RBAG_ASSERT(label, clk, rst_n, prop, msg)
`define RBAG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: src/rbag_pkg.sv
// shared types and constants of the rotated blit address generator
// no dependencies
package rbag_pkg;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int QT_W      = 2;
  localparam int SRC_W     = 24;
  localparam int DST_W     = 22;

  localparam int MAX_DIM_DEF = 2048;
  localparam int BPP_DEF     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_SCREEN_WIDTH  = 3'd2,
    CFG_SCREEN_HEIGHT = 3'd3,
    CFG_ROW_STRIDE    = 3'd4,
    CFG_QUARTER_TURNS = 3'd5
  } cfg_reg_t;

  typedef enum logic [QT_W-1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  // control travelling with a request from the walk stage to the address stage
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

FILE: src/rotated_blit_address_generator.sv
// top level of the rotated, centred blit address generator
// depends on rbag_pkg, rbag_cfg, rbag_walk and rbag_addr
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_index, cfg_wdata
//   in       in         in_valid / in_stall  in_restart
//   out      out        out_valid / out_stall out_source_offset, out_dest_address,
//                                            out_last_pixel
//
// one request per clock sustained while out_stall stays low; the walk register
// and the output register form a two-deep pipeline, so a new request is taken
// while a finished result waits on out_stall
// in_stall rises only when both stages hold results and out_stall is high
// synchronous active-low reset: walk idle until a request with restart set,
// registers back to one (quarter turns to zero)
// an idle request without restart is consumed and gives no result
module rotated_blit_address_generator #(
  parameter int MAX_DIM         = rbag_pkg::MAX_DIM_DEF,
  parameter int BYTES_PER_PIXEL = rbag_pkg::BPP_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [rbag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbag_pkg::CFG_W-1:0]     cfg_wdata,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_restart,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rbag_pkg::SRC_W-1:0]     out_source_offset,
  output logic [rbag_pkg::DST_W-1:0]     out_dest_address,
  output logic                           out_last_pixel
);

  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int CW  = $clog2(MAX_DIM);
  localparam int IBW = $clog2(MAX_DIM * BYTES_PER_PIXEL + 1);

  // geometry, to be settled by the user while the block is idle; the block itself does not enforce it
  logic [DW-1:0]             img_w, img_h, copy_w, copy_h, stride;
  logic [CW-1:0]             off_x, off_y;
  logic [rbag_pkg::QT_W-1:0] quarter_turns;
  logic [IBW-1:0]            img_w_bytes;

  // walk stage to address stage
  rbag_pkg::stage_ctl_t s1_ctl;
  logic [CW-1:0]        s1_col, s1_row, s1_sx, s1_sy;
  logic                 s2_ready;

  // register file plus clamped sizes, clipped region and centring offsets
  rbag_cfg #(
    .MAX_DIM (MAX_DIM),
    .BPP     (BYTES_PER_PIXEL)
  ) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .img_w         (img_w),
    .img_h         (img_h),
    .copy_w        (copy_w),
    .copy_h        (copy_h),
    .off_x         (off_x),
    .off_y         (off_y),
    .stride        (stride),
    .quarter_turns (quarter_turns),
    .img_w_bytes   (img_w_bytes)
  );

  // row-major walk of the region; rotation maps the position to clamped source x/y
  rbag_walk #(
    .MAX_DIM (MAX_DIM)
  ) u_walk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_restart    (in_restart),
    .img_w         (img_w),
    .img_h         (img_h),
    .copy_w        (copy_w),
    .copy_h        (copy_h),
    .quarter_turns (quarter_turns),
    .s2_ready      (s2_ready),
    .s1_ctl        (s1_ctl),
    .s1_col        (s1_col),
    .s1_row        (s1_row),
    .s1_sx         (s1_sx),
    .s1_sy         (s1_sy)
  );

  // one multiply-add per address, straight into the output register
  rbag_addr #(
    .MAX_DIM (MAX_DIM),
    .BPP     (BYTES_PER_PIXEL)
  ) u_addr (
    .clk               (clk),
    .rst_n             (rst_n),
    .s1_ctl            (s1_ctl),
    .s1_col            (s1_col),
    .s1_row            (s1_row),
    .s1_sx             (s1_sx),
    .s1_sy             (s1_sy),
    .off_x             (off_x),
    .off_y             (off_y),
    .stride            (stride),
    .img_w_bytes       (img_w_bytes),
    .s2_ready          (s2_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_source_offset (out_source_offset),
    .out_dest_address  (out_dest_address),
    .out_last_pixel    (out_last_pixel)
  );

endmodule

FILE: src/rbag_cfg.sv
// configuration registers and derived copy-region geometry
// depends on rbag_pkg
module rbag_cfg #(
  parameter int MAX_DIM = rbag_pkg::MAX_DIM_DEF,
  parameter int BPP     = rbag_pkg::BPP_DEF,
  localparam int DW     = $clog2(MAX_DIM + 1),
  localparam int CW     = $clog2(MAX_DIM),
  localparam int IBW    = $clog2(MAX_DIM * BPP + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rbag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbag_pkg::CFG_W-1:0]     cfg_wdata,
  output logic [DW-1:0]                  img_w,
  output logic [DW-1:0]                  img_h,
  output logic [DW-1:0]                  copy_w,
  output logic [DW-1:0]                  copy_h,
  output logic [CW-1:0]                  off_x,
  output logic [CW-1:0]                  off_y,
  output logic [DW-1:0]                  stride,
  output logic [rbag_pkg::QT_W-1:0]      quarter_turns,
  output logic [IBW-1:0]                 img_w_bytes
);

  logic [rbag_pkg::CFG_W-1:0] img_w_r, img_h_r, scr_w_r, scr_h_r, stride_r;
  logic [rbag_pkg::QT_W-1:0]  qt_r;
  logic [DW-1:0]              scr_w, scr_h, rot_w, rot_h;

  // zero reads as one, oversize reads as the largest dimension
  function automatic logic [DW-1:0] dim_of(input logic [rbag_pkg::CFG_W-1:0] v);
    logic [DW-1:0] d;
    if (v == '0) begin
      d = DW'(1);
    end else if (int'(v) > MAX_DIM) begin
      d = DW'(MAX_DIM);
    end else begin
      d = DW'(v);
    end
    return d;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r  <= rbag_pkg::CFG_W'(1);
      img_h_r  <= rbag_pkg::CFG_W'(1);
      scr_w_r  <= rbag_pkg::CFG_W'(1);
      scr_h_r  <= rbag_pkg::CFG_W'(1);
      stride_r <= rbag_pkg::CFG_W'(1);
      qt_r     <= rbag_pkg::ROT_0;
    end else if (cfg_we) begin
      case (cfg_index)
        rbag_pkg::CFG_IMAGE_WIDTH:   img_w_r  <= cfg_wdata;
        rbag_pkg::CFG_IMAGE_HEIGHT:  img_h_r  <= cfg_wdata;
        rbag_pkg::CFG_SCREEN_WIDTH:  scr_w_r  <= cfg_wdata;
        rbag_pkg::CFG_SCREEN_HEIGHT: scr_h_r  <= cfg_wdata;
        rbag_pkg::CFG_ROW_STRIDE:    stride_r <= cfg_wdata;
        rbag_pkg::CFG_QUARTER_TURNS: qt_r     <= cfg_wdata[rbag_pkg::QT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    img_w         = dim_of(img_w_r);
    img_h         = dim_of(img_h_r);
    scr_w         = dim_of(scr_w_r);
    scr_h         = dim_of(scr_h_r);
    stride        = dim_of(stride_r);
    quarter_turns = qt_r;
    // odd quarter turns swap the image axes
    rot_w         = qt_r[0] ? img_h : img_w;
    rot_h         = qt_r[0] ? img_w : img_h;
    copy_w        = (rot_w < scr_w) ? rot_w : scr_w;
    copy_h        = (rot_h < scr_h) ? rot_h : scr_h;
    off_x         = CW'((scr_w - copy_w) >> 1);
    off_y         = CW'((scr_h - copy_h) >> 1);
    img_w_bytes   = IBW'(int'(img_w) * BPP);
  end

endmodule

FILE: src/rbag_walk.sv
// region walk: column/row state, request handshake, source coordinates
// depends on rbag_pkg and the assertion macro header
`include "rotated_blit_address_generator_assert.svh"
module rbag_walk #(
  parameter int MAX_DIM = rbag_pkg::MAX_DIM_DEF,
  localparam int DW     = $clog2(MAX_DIM + 1),
  localparam int CW     = $clog2(MAX_DIM),
  localparam int SW     = DW + 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_restart,
  input  logic [DW-1:0]             img_w,
  input  logic [DW-1:0]             img_h,
  input  logic [DW-1:0]             copy_w,
  input  logic [DW-1:0]             copy_h,
  input  logic [rbag_pkg::QT_W-1:0] quarter_turns,
  input  logic                      s2_ready,
  output rbag_pkg::stage_ctl_t      s1_ctl,
  output logic [CW-1:0]             s1_col,
  output logic [CW-1:0]             s1_row,
  output logic [CW-1:0]             s1_sx,
  output logic [CW-1:0]             s1_sy
);

  logic [CW-1:0]        column_r, column_nxt, row_r, row_nxt;
  logic                 finished_r, finished_nxt;
  rbag_pkg::stage_ctl_t s1_ctl_r, s1_ctl_nxt;
  logic [CW-1:0]        s1_col_r, s1_row_r, s1_sx_r, s1_sy_r;
  logic                 s1_ready, accept, emit, end_col, end_row;
  logic [CW-1:0]        col_cur, row_cur;
  logic signed [SW-1:0] c_s, r_s, iw_m1, ih_m1, sx_raw, sy_raw;

  function automatic logic [CW-1:0] clamp_coord(input logic signed [SW-1:0] v,
                                                input logic [DW-1:0] size);
    logic [CW-1:0] o;
    if (v < 0) begin
      o = '0;
    end else if (v >= $signed(SW'(size))) begin
      o = CW'(size - DW'(1));
    end else begin
      o = CW'(v);
    end
    return o;
  endfunction

  always_comb begin
    s1_ready = !s1_ctl_r.valid || s2_ready;
    in_stall = !s1_ready;
    accept   = in_valid && s1_ready;
    col_cur  = in_restart ? '0 : column_r;
    row_cur  = in_restart ? '0 : row_r;
    emit     = accept && (in_restart || !finished_r);
    end_col  = (DW'(col_cur) + DW'(1)) >= copy_w;
    end_row  = (DW'(row_cur) + DW'(1)) >= copy_h;

    column_nxt   = column_r;
    row_nxt      = row_r;
    finished_nxt = finished_r;
    if (emit) begin
      if (!end_col) begin
        column_nxt   = CW'(DW'(col_cur) + DW'(1));
        row_nxt      = row_cur;
        finished_nxt = 1'b0;
      end else begin
        column_nxt = '0;
        if (!end_row) begin
          row_nxt      = CW'(DW'(row_cur) + DW'(1));
          finished_nxt = 1'b0;
        end else begin
          row_nxt      = '0;
          finished_nxt = 1'b1;
        end
      end
    end

    c_s   = $signed(SW'(col_cur));
    r_s   = $signed(SW'(row_cur));
    iw_m1 = $signed(SW'(img_w)) - SW'(1);
    ih_m1 = $signed(SW'(img_h)) - SW'(1);
    case (quarter_turns)
      rbag_pkg::ROT_0: begin
        sx_raw = c_s;
        sy_raw = r_s;
      end
      rbag_pkg::ROT_90: begin
        sx_raw = iw_m1 - r_s;
        sy_raw = c_s;
      end
      rbag_pkg::ROT_180: begin
        sx_raw = iw_m1 - c_s;
        sy_raw = ih_m1 - r_s;
      end
      default: begin
        sx_raw = r_s;
        sy_raw = ih_m1 - c_s;
      end
    endcase

    s1_ctl_nxt = s1_ctl_r;
    if (s1_ready) begin
      s1_ctl_nxt.valid = emit;
      s1_ctl_nxt.last  = end_col && end_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= '0;
      row_r      <= '0;
      finished_r <= 1'b1;
      s1_ctl_r   <= '0;
    end else begin
      column_r   <= column_nxt;
      row_r      <= row_nxt;
      finished_r <= finished_nxt;
      s1_ctl_r   <= s1_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_col_r <= col_cur;
      s1_row_r <= row_cur;
      s1_sx_r  <= clamp_coord(sx_raw, img_w);
      s1_sy_r  <= clamp_coord(sy_raw, img_h);
    end
  end

  assign s1_ctl = s1_ctl_r;
  assign s1_col = s1_col_r;
  assign s1_row = s1_row_r;
  assign s1_sx  = s1_sx_r;
  assign s1_sy  = s1_sy_r;

  `RBAG_ASSERT(a_idle_at_origin, clk, rst_n, finished_r |-> (column_r == '0) && (row_r == '0), "idle walk not parked at the region origin")
  `RBAG_ASSERT_NEXT(a_idle_no_request, clk, rst_n, accept && finished_r && !in_restart, !s1_ctl_r.valid, "request issued while idle")
  `RBAG_ASSERT_NEXT(a_last_goes_idle, clk, rst_n, emit && end_col && end_row, finished_r, "walk did not stop after the last pixel")

endmodule

FILE: src/rbag_addr.sv
// address stage: source offset and destination address into the output register
// depends on rbag_pkg
module rbag_addr #(
  parameter int MAX_DIM = rbag_pkg::MAX_DIM_DEF,
  parameter int BPP     = rbag_pkg::BPP_DEF,
  localparam int DW     = $clog2(MAX_DIM + 1),
  localparam int CW     = $clog2(MAX_DIM),
  localparam int IBW    = $clog2(MAX_DIM * BPP + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rbag_pkg::stage_ctl_t         s1_ctl,
  input  logic [CW-1:0]                s1_col,
  input  logic [CW-1:0]                s1_row,
  input  logic [CW-1:0]                s1_sx,
  input  logic [CW-1:0]                s1_sy,
  input  logic [CW-1:0]                off_x,
  input  logic [CW-1:0]                off_y,
  input  logic [DW-1:0]                stride,
  input  logic [IBW-1:0]               img_w_bytes,
  output logic                         s2_ready,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rbag_pkg::SRC_W-1:0]   out_source_offset,
  output logic [rbag_pkg::DST_W-1:0]   out_dest_address,
  output logic                         out_last_pixel
);

  logic                       out_valid_r;
  logic [rbag_pkg::SRC_W-1:0] src_r, src_nxt;
  logic [rbag_pkg::DST_W-1:0] dst_r, dst_nxt;
  logic                       last_r;

  always_comb begin
    s2_ready = !out_valid_r || !out_stall;
    // sy*(width*bpp) + sx*bpp, wrapping at the field width
    src_nxt  = rbag_pkg::SRC_W'(s1_sy) * rbag_pkg::SRC_W'(img_w_bytes)
             + rbag_pkg::SRC_W'(int'(s1_sx) * BPP);
    dst_nxt  = (rbag_pkg::DST_W'(off_y) + rbag_pkg::DST_W'(s1_row)) * rbag_pkg::DST_W'(stride)
             + rbag_pkg::DST_W'(off_x) + rbag_pkg::DST_W'(s1_col);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_ctl.valid) begin
      src_r  <= src_nxt;
      dst_r  <= dst_nxt;
      last_r <= s1_ctl.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_source_offset = src_r;
  assign out_dest_address  = dst_r;
  assign out_last_pixel    = last_r;

endmodule
